>>> sv/smc_mbx_pkg.sv
package smc_mbx_pkg;

  // Fixed framing of a transaction header: command, key bytes, length byte
  localparam int unsigned KeyBytes = 4;
  localparam int unsigned HdrBytes = 1 + KeyBytes + 1;

  // Configuration register indexes and reset values
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_MIN_WAIT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_WAIT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_POLLS  = 2'd2;
  localparam logic [15:0] MinWaitRst   = 16'h0010;
  localparam logic [15:0] RetryWaitRst = 16'h0100;
  localparam logic [4:0]  MaxPollsRst  = 5'd18;

  // Delay counters are 40 bits, saturating
  localparam int unsigned WaitW = 40;

  // Input item kinds
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESP  = 2'd1,
    OP_LOAD  = 2'd2,
    OP_START = 2'd3
  } op_e;

  // Bus operations requested from the host
  typedef enum logic [2:0] {
    BUS_NONE      = 3'd0,
    BUS_RD_STATUS = 3'd1,
    BUS_RD_DATA   = 3'd2,
    BUS_WR_CMD    = 3'd3,
    BUS_WR_DATA   = 3'd4
  } bus_op_e;

  // Completion status
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_IO_ERR = 2'd1,
    ST_BUSY   = 2'd2
  } status_e;

  // Transaction phase, one-hot
  typedef enum logic [8:0] {
    PH_IDLE           = 9'b0_0000_0001,
    PH_WAIT_SEND      = 9'b0_0000_0010,
    PH_RESP_SEND      = 9'b0_0000_0100,
    PH_WAIT_RDY       = 9'b0_0000_1000,
    PH_RESP_RDY       = 9'b0_0001_0000,
    PH_RESP_DATA      = 9'b0_0010_0000,
    PH_WAIT_FLUSH     = 9'b0_0100_0000,
    PH_RESP_FLUSH     = 9'b0_1000_0000,
    PH_RESP_FLUSHDATA = 9'b1_0000_0000
  } phase_e;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    A_NOP,
    A_LOAD,
    A_EMIT_BUSY,
    A_LATCH,
    A_MEM_RD,
    A_BEGIN_SEND,
    A_DEC,
    A_POLL_SEND,
    A_RESEND,
    A_POLL_RDY,
    A_POLL_FLUSH,
    A_REPOLL_SEND,
    A_NEXT_BYTE,
    A_CLR_BC,
    A_READY_WAIT,
    A_FIN_ERR,
    A_FIN_OK,
    A_BEGIN_FLUSH,
    A_REPOLL_RDY,
    A_READ_DATA,
    A_GOT_DATA,
    A_READ_FLUSH,
    A_FLUSH_INC,
    A_WAIT_FLUSH
  } uop_e;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_WAIT_LEFT,
    C_RETRY,
    C_ACCEPTED,
    C_LAST_POLL,
    C_MORE,
    C_WMODE,
    C_LEN_ZERO,
    C_S0,
    C_S0_CLEAR,
    C_DATA_LAST,
    C_FLUSH_DONE
  } cond_e;

  localparam int unsigned UpcW     = 6;
  localparam int unsigned NumSteps = 35;
  typedef logic [UpcW-1:0] upc_t;

  typedef struct packed {
    uop_e  uop;
    cond_e cond;
    logic  emit;
    upc_t  target;
  } ctrl_word_t;

  typedef struct packed {
    bus_op_e     bus_op;
    logic [7:0]  bus_value;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        data_last;
    logic        done_res;
    status_e     status;
  } out_item_t;

  // Routine entry points
  localparam upc_t U_IDLE  = 6'd0;
  localparam upc_t U_LOAD  = 6'd1;
  localparam upc_t U_BUSY  = 6'd2;
  localparam upc_t U_START = 6'd3;
  localparam upc_t U_SEND  = 6'd4;
  localparam upc_t U_TS    = 6'd6;
  localparam upc_t U_TS_RS = 6'd9;
  localparam upc_t U_TR    = 6'd10;
  localparam upc_t U_TF    = 6'd12;
  localparam upc_t U_RS    = 6'd14;
  localparam upc_t U_RS_OK = 6'd17;
  localparam upc_t U_FAIL  = 6'd22;
  localparam upc_t U_OK    = 6'd23;
  localparam upc_t U_FLUSH = 6'd24;
  localparam upc_t U_RR    = 6'd25;
  localparam upc_t U_RR_RD = 6'd28;
  localparam upc_t U_RD    = 6'd29;
  localparam upc_t U_RF    = 6'd31;
  localparam upc_t U_RX    = 6'd33;

  // Microprogram: on a false condition control falls through to the next word
  localparam ctrl_word_t UCODE [NumSteps] = '{
    '{A_NOP,         C_NEVER,      1'b0, U_IDLE },  //  0 wait for an item
    '{A_LOAD,        C_ALWAYS,     1'b0, U_IDLE },  //  1 buffer load
    '{A_EMIT_BUSY,   C_ALWAYS,     1'b1, U_IDLE },  //  2 start rejected
    '{A_LATCH,       C_ALWAYS,     1'b0, U_SEND },  //  3 start accepted
    '{A_MEM_RD,      C_NEVER,      1'b0, U_IDLE },  //  4 send: fetch payload
    '{A_BEGIN_SEND,  C_ALWAYS,     1'b1, U_IDLE },  //  5 send: write byte
    '{A_DEC,         C_WAIT_LEFT,  1'b0, U_IDLE },  //  6 tick in send wait
    '{A_NOP,         C_RETRY,      1'b0, U_TS_RS},  //  7
    '{A_POLL_SEND,   C_ALWAYS,     1'b1, U_IDLE },  //  8 status poll
    '{A_RESEND,      C_ALWAYS,     1'b1, U_IDLE },  //  9 resend byte
    '{A_DEC,         C_WAIT_LEFT,  1'b0, U_IDLE },  // 10 tick in ready wait
    '{A_POLL_RDY,    C_ALWAYS,     1'b1, U_IDLE },  // 11
    '{A_DEC,         C_WAIT_LEFT,  1'b0, U_IDLE },  // 12 tick in flush wait
    '{A_POLL_FLUSH,  C_ALWAYS,     1'b1, U_IDLE },  // 13
    '{A_NOP,         C_ACCEPTED,   1'b0, U_RS_OK},  // 14 status after send
    '{A_NOP,         C_LAST_POLL,  1'b0, U_FAIL },  // 15
    '{A_REPOLL_SEND, C_ALWAYS,     1'b0, U_IDLE },  // 16
    '{A_NEXT_BYTE,   C_NEVER,      1'b0, U_IDLE },  // 17 byte taken
    '{A_NOP,         C_MORE,       1'b0, U_SEND },  // 18
    '{A_NOP,         C_WMODE,      1'b0, U_OK   },  // 19
    '{A_CLR_BC,      C_LEN_ZERO,   1'b0, U_FLUSH},  // 20
    '{A_READY_WAIT,  C_ALWAYS,     1'b0, U_IDLE },  // 21
    '{A_FIN_ERR,     C_ALWAYS,     1'b1, U_IDLE },  // 22 timeout
    '{A_FIN_OK,      C_ALWAYS,     1'b1, U_IDLE },  // 23 success
    '{A_BEGIN_FLUSH, C_ALWAYS,     1'b0, U_IDLE },  // 24
    '{A_NOP,         C_S0,         1'b0, U_RR_RD},  // 25 status in ready wait
    '{A_NOP,         C_LAST_POLL,  1'b0, U_FAIL },  // 26
    '{A_REPOLL_RDY,  C_ALWAYS,     1'b0, U_IDLE },  // 27
    '{A_READ_DATA,   C_ALWAYS,     1'b1, U_IDLE },  // 28
    '{A_GOT_DATA,    C_DATA_LAST,  1'b1, U_FLUSH},  // 29 data byte arrived
    '{A_READY_WAIT,  C_ALWAYS,     1'b0, U_IDLE },  // 30
    '{A_NOP,         C_S0_CLEAR,   1'b0, U_OK   },  // 31 status in flush
    '{A_READ_FLUSH,  C_ALWAYS,     1'b1, U_IDLE },  // 32
    '{A_FLUSH_INC,   C_FLUSH_DONE, 1'b0, U_OK   },  // 33 flushed byte
    '{A_WAIT_FLUSH,  C_ALWAYS,     1'b0, U_IDLE }   // 34
  };

  // Routine selected by the item kind and the current phase
  function automatic upc_t dispatch(op_e op, phase_e ph);
    upc_t res;
    res = U_IDLE;
    case (op)
      OP_LOAD:  res = U_LOAD;
      OP_START: res = (ph == PH_IDLE) ? U_START : U_BUSY;
      OP_TICK: begin
        case (ph)
          PH_WAIT_SEND:  res = U_TS;
          PH_WAIT_RDY:   res = U_TR;
          PH_WAIT_FLUSH: res = U_TF;
          default:       res = U_IDLE;
        endcase
      end
      OP_RESP: begin
        case (ph)
          PH_RESP_SEND:      res = U_RS;
          PH_RESP_RDY:       res = U_RR;
          PH_RESP_DATA:      res = U_RD;
          PH_RESP_FLUSH:     res = U_RF;
          PH_RESP_FLUSHDATA: res = U_RX;
          default:           res = U_IDLE;
        endcase
      end
      default: res = U_IDLE;
    endcase
    return res;
  endfunction

endpackage

>>> sv/smc_mailbox_port_master.sv
// Host-side master for a byte-wide command/data mailbox.
// Input stream (s_axis): one item per transfer; tuser carries the kind (tick,
// bus read response, payload load, start) and tdata the start, load and
// response fields. Output stream (m_axis): at most one item per input item,
// either a bus operation for the host to perform, a received payload byte
// (tlast on the final one) or a completion with its status.
// Configuration: cfg_we_i writes cfg_wdata_i into the register cfg_idx_i in
// the same cycle (0 first poll delay, 1 resend delay, 2 polls per byte);
// write only while no transaction is running.
// Sequencing: a microcoded sequencer runs a short routine per item, chosen by
// the item kind and the current phase. s_axis_tready is high only while the
// sequencer waits for its next item. Delays are counted in tick items, not
// clock cycles.
// Results sit in an output register; a step that produces a result waits
// there while the previous one is still not taken, so a stalled receiver
// holds back the input side after at most one pending result.
// Reset clears the phase to idle and restores the register defaults; the
// payload buffer holds nothing meaningful until loaded.
module smc_mailbox_port_master
  import smc_mbx_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32,
  parameter int unsigned FLUSH_LIMIT = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: is_write[0], command[8:1], key[40:9], length[46:41],
  //        byte_value[54:47], byte_index[59:55], zero pad [63:60]
  input  logic [63:0]         s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [1:0]          s_axis_tuser,
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: bus_value[7:0], data_byte[15:8], status[17:16], zero pad [23:18]
  output logic [23:0]         m_axis_tdata,
  // tuser: bus_op[2:0], data_valid[3], done_res[4]
  output logic [4:0]          m_axis_tuser,
  output logic                m_axis_tlast
);

  localparam int unsigned AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned LenW  = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned BcW   = $clog2(HdrBytes + MAX_PAYLOAD + 1);
  localparam int unsigned FcW   = $clog2(FLUSH_LIMIT + 1);

  // Configuration registers
  logic [15:0] min_wait_q, retry_wait_q;
  logic [4:0]  max_polls_q;

  // Sequencer and latched item
  upc_t        upc_q, upc_d;
  ctrl_word_t  word;
  logic        out_free, stall, run, cond_true, accept;
  op_e         it_op_q;
  logic        it_wr_q;
  logic [7:0]  it_cmd_q, it_bv_q;
  logic [31:0] it_key_q;
  logic [5:0]  it_len_q;
  logic [4:0]  it_bi_q;

  // Transaction datapath
  phase_e           phase_q, phase_d;
  logic [BcW-1:0]   bc_q, bc_d;
  logic [4:0]       poll_q, poll_d;
  logic [WaitW-1:0] rem_q, rem_d, delay_q, delay_d;
  logic [WaitW-1:0] min40, retry40, dbl;
  logic [7:0]       pend_q, pend_d;
  logic             retry_q, retry_d;
  logic [FcW-1:0]   fc_q, fc_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [31:0]      key_q, key_d, key_shift;
  logic [LenW-1:0]  hlen_q, hlen_d, len_sat;
  logic             wmode_q, wmode_d;
  logic [7:0]       tx_byte;
  bus_op_e          send_op;

  // Payload buffer
  logic [7:0]       mem_q [MAX_PAYLOAD];
  logic [7:0]       rdata_q;
  logic [AddrW-1:0] rd_addr, ld_addr;
  logic             ld_ok;

  // Output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d, em;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_wait_q   <= MinWaitRst;
      retry_wait_q <= RetryWaitRst;
      max_polls_q  <= MaxPollsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_WAIT:   min_wait_q   <= cfg_wdata_i[15:0];
        CFG_RETRY_WAIT: retry_wait_q <= cfg_wdata_i[15:0];
        CFG_MAX_POLLS:  max_polls_q  <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // Sequencer control
  assign word          = UCODE[upc_q];
  assign out_free      = !out_valid_q || m_axis_tready;
  assign stall         = word.emit && !out_free;
  assign run           = (upc_q != U_IDLE) && !stall;
  assign s_axis_tready = (upc_q == U_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Derived datapath values
  assign min40   = WaitW'(min_wait_q);
  assign retry40 = WaitW'(retry_wait_q);
  assign dbl     = delay_q[WaitW-1] ? '1 : {delay_q[WaitW-2:0], 1'b0};
  assign len_sat = ({1'b0, it_len_q} > 7'(MAX_PAYLOAD)) ? LenW'(MAX_PAYLOAD)
                                                         : LenW'(it_len_q);
  assign rd_addr = AddrW'(bc_q - BcW'(HdrBytes));
  assign ld_addr = AddrW'(it_bi_q);
  assign ld_ok   = (32'(it_bi_q) < MAX_PAYLOAD);

  // Byte to send at position bc: command, key high byte first, length, payload
  assign key_shift = key_q << {2'(bc_q[1:0] - 2'd1), 3'b000};
  always_comb begin
    if (bc_q == '0) begin
      tx_byte = cmd_q;
    end else if (bc_q < BcW'(HdrBytes - 1)) begin
      tx_byte = key_shift[31:24];
    end else if (bc_q == BcW'(HdrBytes - 1)) begin
      tx_byte = 8'(hlen_q);
    end else begin
      tx_byte = rdata_q;
    end
  end
  assign send_op = (bc_q == '0) ? BUS_WR_CMD : BUS_WR_DATA;

  // Jump condition
  always_comb begin
    case (word.cond)
      C_NEVER:      cond_true = 1'b0;
      C_ALWAYS:     cond_true = 1'b1;
      C_WAIT_LEFT:  cond_true = |rem_q[WaitW-1:1];
      C_RETRY:      cond_true = retry_q;
      C_ACCEPTED:   cond_true = !it_bv_q[1] && it_bv_q[2];
      C_LAST_POLL:  cond_true = (6'(poll_q) + 6'd1) >= 6'(max_polls_q);
      C_MORE:       cond_true = (bc_q < BcW'(HdrBytes)) ||
                                (wmode_q && (bc_q < BcW'(HdrBytes) + BcW'(hlen_q)));
      C_WMODE:      cond_true = wmode_q;
      C_LEN_ZERO:   cond_true = (hlen_q == '0);
      C_S0:         cond_true = it_bv_q[0];
      C_S0_CLEAR:   cond_true = !it_bv_q[0];
      C_DATA_LAST:  cond_true = (bc_q + BcW'(1)) >= BcW'(hlen_q);
      C_FLUSH_DONE: cond_true = (fc_q + FcW'(1)) >= FcW'(FLUSH_LIMIT);
      default:      cond_true = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    upc_d = upc_q;
    if (upc_q == U_IDLE) begin
      if (accept) begin
        upc_d = dispatch(op_e'(s_axis_tuser), phase_q);
      end
    end else if (!stall) begin
      upc_d = cond_true ? word.target : upc_q + upc_t'(1);
    end
  end

  // Datapath: one micro-operation per step
  always_comb begin
    phase_d = phase_q;
    bc_d    = bc_q;
    poll_d  = poll_q;
    rem_d   = rem_q;
    delay_d = delay_q;
    pend_d  = pend_q;
    retry_d = retry_q;
    fc_d    = fc_q;
    cmd_d   = cmd_q;
    key_d   = key_q;
    hlen_d  = hlen_q;
    wmode_d = wmode_q;
    em      = '0;
    if (run) begin
      case (word.uop)
        A_EMIT_BUSY: begin
          em.done_res = 1'b1;
          em.status   = ST_BUSY;
        end
        A_LATCH: begin
          wmode_d = it_wr_q;
          cmd_d   = it_cmd_q;
          key_d   = it_key_q;
          hlen_d  = len_sat;
          bc_d    = '0;
        end
        A_BEGIN_SEND: begin
          pend_d       = tx_byte;
          poll_d       = '0;
          retry_d      = 1'b0;
          delay_d      = min40;
          rem_d        = min40;
          phase_d      = PH_WAIT_SEND;
          em.bus_op    = send_op;
          em.bus_value = tx_byte;
        end
        A_DEC: begin
          if (rem_q != '0) begin
            rem_d = rem_q - WaitW'(1);
          end
        end
        A_POLL_SEND: begin
          phase_d   = PH_RESP_SEND;
          em.bus_op = BUS_RD_STATUS;
        end
        A_RESEND: begin
          retry_d      = 1'b0;
          rem_d        = delay_q;
          em.bus_op    = send_op;
          em.bus_value = pend_q;
        end
        A_POLL_RDY: begin
          phase_d   = PH_RESP_RDY;
          em.bus_op = BUS_RD_STATUS;
        end
        A_POLL_FLUSH: begin
          phase_d   = PH_RESP_FLUSH;
          em.bus_op = BUS_RD_STATUS;
        end
        A_REPOLL_SEND: begin
          poll_d  = poll_q + 5'd1;
          delay_d = dbl;
          phase_d = PH_WAIT_SEND;
          if (it_bv_q[1]) begin
            rem_d = dbl;
          end else begin
            retry_d = 1'b1;
            rem_d   = retry40;
          end
        end
        A_NEXT_BYTE: bc_d = bc_q + BcW'(1);
        A_CLR_BC:    bc_d = '0;
        A_READY_WAIT: begin
          poll_d  = '0;
          delay_d = min40;
          rem_d   = min40;
          phase_d = PH_WAIT_RDY;
        end
        A_FIN_ERR: begin
          phase_d     = PH_IDLE;
          em.done_res = 1'b1;
          em.status   = ST_IO_ERR;
        end
        A_FIN_OK: begin
          phase_d     = PH_IDLE;
          em.done_res = 1'b1;
          em.status   = ST_OK;
        end
        A_BEGIN_FLUSH: begin
          fc_d    = '0;
          rem_d   = min40;
          phase_d = PH_WAIT_FLUSH;
        end
        A_REPOLL_RDY: begin
          poll_d  = poll_q + 5'd1;
          delay_d = dbl;
          rem_d   = dbl;
          phase_d = PH_WAIT_RDY;
        end
        A_READ_DATA: begin
          phase_d   = PH_RESP_DATA;
          em.bus_op = BUS_RD_DATA;
        end
        A_GOT_DATA: begin
          bc_d          = bc_q + BcW'(1);
          em.data_valid = 1'b1;
          em.data_byte  = it_bv_q;
          em.data_last  = cond_true;
        end
        A_READ_FLUSH: begin
          phase_d   = PH_RESP_FLUSHDATA;
          em.bus_op = BUS_RD_DATA;
        end
        A_FLUSH_INC: fc_d = fc_q + FcW'(1);
        A_WAIT_FLUSH: begin
          rem_d   = min40;
          phase_d = PH_WAIT_FLUSH;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    if (run && word.emit) begin
      out_valid_d = 1'b1;
      out_d       = em;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= U_IDLE;
      phase_q     <= PH_IDLE;
      bc_q        <= '0;
      poll_q      <= '0;
      rem_q       <= '0;
      delay_q     <= '0;
      pend_q      <= '0;
      retry_q     <= 1'b0;
      fc_q        <= '0;
      cmd_q       <= '0;
      key_q       <= '0;
      hlen_q      <= '0;
      wmode_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      phase_q     <= phase_d;
      bc_q        <= bc_d;
      poll_q      <= poll_d;
      rem_q       <= rem_d;
      delay_q     <= delay_d;
      pend_q      <= pend_d;
      retry_q     <= retry_d;
      fc_q        <= fc_d;
      cmd_q       <= cmd_d;
      key_q       <= key_d;
      hlen_q      <= hlen_d;
      wmode_q     <= wmode_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      it_op_q  <= op_e'(s_axis_tuser);
      it_wr_q  <= s_axis_tdata[0];
      it_cmd_q <= s_axis_tdata[8:1];
      it_key_q <= s_axis_tdata[40:9];
      it_len_q <= s_axis_tdata[46:41];
      it_bv_q  <= s_axis_tdata[54:47];
      it_bi_q  <= s_axis_tdata[59:55];
    end
  end

  // Payload buffer: one write port for loads, one registered read port
  always_ff @(posedge clk_i) begin
    if (run && (word.uop == A_LOAD) && (it_op_q == OP_LOAD) && ld_ok) begin
      mem_q[ld_addr] <= it_bv_q;
    end
    if (run && (word.uop == A_MEM_RD) && (bc_q >= BcW'(HdrBytes))) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Output packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.status, out_q.data_byte, out_q.bus_value};
  assign m_axis_tuser  = {out_q.done_res, out_q.data_valid, out_q.bus_op};
  assign m_axis_tlast  = out_q.data_last;

`ifndef SYNTHESIS
  a_upc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upc_q < upc_t'(NumSteps))
    else $error("microcode step out of range");

  a_len_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(hlen_q) <= MAX_PAYLOAD)
    else $error("held length above buffer size");

  a_flush_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WAIT_FLUSH) |-> (32'(fc_q) < FLUSH_LIMIT))
    else $error("flush count reached limit while still flushing");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((upc_q == U_OK) || (upc_q == U_FAIL)) && out_free |=> (phase_q == PH_IDLE))
    else $error("transaction end did not return to idle");

  a_out_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.data_valid || out_q.done_res) |->
      (out_q.bus_op == BUS_NONE) && !(out_q.data_valid && out_q.done_res))
    else $error("result mixes bus operation, data and completion");
`endif

endmodule
